[sv/lsd_pkg.sv]
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int PIX_W      = $clog2(MAX_PIXELS);
    localparam int COUNT_W    = 7;
    localparam int PULSE_W    = 8;
    localparam int TICK_W     = 12;
    localparam int LEVEL_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int WORD_W     = 3 * COLOR_W;
    localparam int BIT_W      = 5;
    localparam int BITS_PER_PIXEL = WORD_W;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_SHOW  = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_BUSY  = 2'd2
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pixel_count;
        logic [PULSE_W-1:0] zero_high_ticks;
        logic [PULSE_W-1:0] zero_low_ticks;
        logic [PULSE_W-1:0] one_high_ticks;
        logic [PULSE_W-1:0] one_low_ticks;
        logic [TICK_W-1:0]  latch_ticks;
    } cfg_t;

    typedef struct packed {
        logic       line_level;
        logic       busy_res;
        logic [1:0] status;
    } result_t;

endpackage

[sv/lsd_ram.sv]
`timescale 1ns / 1ps

module lsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/lsd_cfg.sv]
`timescale 1ns / 1ps

module lsd_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output lsd_pkg::cfg_t        cfg
);

    localparam logic [2:0] REG_PIXEL_COUNT = 3'd0;
    localparam logic [2:0] REG_ZERO_HIGH   = 3'd1;
    localparam logic [2:0] REG_ZERO_LOW    = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [2:0] REG_ONE_LOW     = 3'd4;
    localparam logic [2:0] REG_LATCH       = 3'd5;

    lsd_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_count     <= lsd_pkg::COUNT_W'(1);
            cfg_reg.zero_high_ticks <= lsd_pkg::PULSE_W'(3);
            cfg_reg.zero_low_ticks  <= lsd_pkg::PULSE_W'(9);
            cfg_reg.one_high_ticks  <= lsd_pkg::PULSE_W'(9);
            cfg_reg.one_low_ticks   <= lsd_pkg::PULSE_W'(3);
            cfg_reg.latch_ticks     <= lsd_pkg::TICK_W'(3000);
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_PIXEL_COUNT: cfg_reg.pixel_count     <= pwdata[lsd_pkg::COUNT_W-1:0];
                REG_ZERO_HIGH:   cfg_reg.zero_high_ticks <= pwdata[lsd_pkg::PULSE_W-1:0];
                REG_ZERO_LOW:    cfg_reg.zero_low_ticks  <= pwdata[lsd_pkg::PULSE_W-1:0];
                REG_ONE_HIGH:    cfg_reg.one_high_ticks  <= pwdata[lsd_pkg::PULSE_W-1:0];
                REG_ONE_LOW:     cfg_reg.one_low_ticks   <= pwdata[lsd_pkg::PULSE_W-1:0];
                REG_LATCH:       cfg_reg.latch_ticks     <= pwdata[lsd_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PIXEL_COUNT: prdata = 32'(cfg_reg.pixel_count);
            REG_ZERO_HIGH:   prdata = 32'(cfg_reg.zero_high_ticks);
            REG_ZERO_LOW:    prdata = 32'(cfg_reg.zero_low_ticks);
            REG_ONE_HIGH:    prdata = 32'(cfg_reg.one_high_ticks);
            REG_ONE_LOW:     prdata = 32'(cfg_reg.one_low_ticks);
            REG_LATCH:       prdata = 32'(cfg_reg.latch_ticks);
            default:         prdata = 32'd0;
        endcase
    end

endmodule

[sv/lsd_engine.sv]
`timescale 1ns / 1ps

module lsd_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsd_pkg::cfg_t                       cfg,
    input  logic                                accept,
    input  logic [1:0]                          mode,
    input  logic [lsd_pkg::PIX_W-1:0]           pixel_index,
    input  logic signed [lsd_pkg::LEVEL_W-1:0]  red_in,
    input  logic signed [lsd_pkg::LEVEL_W-1:0]  green_in,
    input  logic signed [lsd_pkg::LEVEL_W-1:0]  blue_in,
    output lsd_pkg::result_t                    result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } phase_t;

    localparam int PIX_W   = lsd_pkg::PIX_W;
    localparam int COUNT_W = lsd_pkg::COUNT_W;
    localparam int TICK_W  = lsd_pkg::TICK_W;
    localparam int WORD_W  = lsd_pkg::WORD_W;
    localparam int BIT_W   = lsd_pkg::BIT_W;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(lsd_pkg::MAX_PIXELS);
    localparam logic [BIT_W-1:0]   LAST_BIT  = BIT_W'(lsd_pkg::BITS_PER_PIXEL);

    function automatic logic [lsd_pkg::COLOR_W-1:0] saturate(
        input logic [lsd_pkg::LEVEL_W-1:0] v
    );
        if (v[lsd_pkg::LEVEL_W-1])
            return '0;
        else if (v > lsd_pkg::LEVEL_W'(255))
            return '1;
        else
            return v[lsd_pkg::COLOR_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    phase_t              phase_reg, phase_c, phase_next;
    logic [PIX_W-1:0]    pos_reg, pos_c, pos_next;
    logic [BIT_W-1:0]    bit_reg, bit_c, bit_next;
    logic [TICK_W-1:0]   tick_reg, tick_c, tick_next;
    logic [WORD_W-1:0]   shift_reg, shift_c, shift_next;

    logic [lsd_pkg::MAX_PIXELS-1:0] valid_reg;
    logic [PIX_W-1:0]    raddr_reg, raddr;
    logic                fwd_hit_reg;
    logic [WORD_W-1:0]   fwd_data_reg;
    logic [WORD_W-1:0]   ram_q;
    logic [WORD_W-1:0]   word;

    logic                we_c, we;
    logic [WORD_W-1:0]   wdata;
    logic [COUNT_W-1:0]  eff_count;
    logic [COUNT_W-1:0]  pos_plus;
    logic [BIT_W-1:0]    bit_plus;
    logic                busy;
    lsd_pkg::status_t    status_c;

    // Word for the prefetched entry: last-cycle write wins, unwritten reads as zero.
    assign word = fwd_hit_reg ? fwd_data_reg :
                  (valid_reg[raddr_reg] ? ram_q : '0);

    assign wdata = {saturate(green_in), saturate(red_in), saturate(blue_in)};

    always_comb
    begin
        if (cfg.pixel_count == '0)
            eff_count = COUNT_W'(1);
        else if (cfg.pixel_count > MAX_COUNT)
            eff_count = MAX_COUNT;
        else
            eff_count = cfg.pixel_count;
    end

    always_comb
    begin
        busy     = (phase_reg != PH_IDLE);
        status_c = lsd_pkg::STATUS_OK;
        we_c     = 1'b0;
        phase_c  = phase_reg;
        pos_c    = pos_reg;
        bit_c    = bit_reg;
        tick_c   = tick_reg;
        shift_c  = shift_reg;

        case (mode)
            lsd_pkg::MODE_WRITE:
            begin
                if (busy)
                    status_c = lsd_pkg::STATUS_BUSY;
                else if (COUNT_W'(pixel_index) >= eff_count)
                    status_c = lsd_pkg::STATUS_RANGE;
                else
                    we_c = 1'b1;
            end
            lsd_pkg::MODE_SHOW:
            begin
                if (busy)
                begin
                    status_c = lsd_pkg::STATUS_BUSY;
                end
                else
                begin
                    // idle keeps entry zero prefetched
                    phase_c = PH_HIGH;
                    pos_c   = '0;
                    bit_c   = '0;
                    shift_c = word;
                    tick_c  = at_least_one(word[WORD_W-1] ?
                                           TICK_W'(cfg.one_high_ticks) :
                                           TICK_W'(cfg.zero_high_ticks));
                end
            end
            default: ;
        endcase

        result.line_level = (phase_c == PH_HIGH);
        result.busy_res   = (phase_c != PH_IDLE);
        result.status     = status_c;

        pos_plus   = COUNT_W'(pos_c) + COUNT_W'(1);
        bit_plus   = bit_c + BIT_W'(1);
        phase_next = phase_c;
        pos_next   = pos_c;
        bit_next   = bit_c;
        tick_next  = tick_c;
        shift_next = shift_c;

        case (phase_c)
            PH_IDLE: ;
            PH_HIGH:
            begin
                if (tick_c > TICK_W'(1))
                begin
                    tick_next = tick_c - TICK_W'(1);
                end
                else
                begin
                    phase_next = PH_LOW;
                    tick_next  = at_least_one(shift_c[WORD_W-1] ?
                                              TICK_W'(cfg.one_low_ticks) :
                                              TICK_W'(cfg.zero_low_ticks));
                end
            end
            PH_LOW:
            begin
                if (tick_c > TICK_W'(1))
                begin
                    tick_next = tick_c - TICK_W'(1);
                end
                else if (bit_plus < LAST_BIT)
                begin
                    bit_next   = bit_plus;
                    shift_next = {shift_c[WORD_W-2:0], 1'b0};
                    phase_next = PH_HIGH;
                    tick_next  = at_least_one(shift_c[WORD_W-2] ?
                                              TICK_W'(cfg.one_high_ticks) :
                                              TICK_W'(cfg.zero_high_ticks));
                end
                else if (pos_plus >= eff_count)
                begin
                    pos_next   = pos_plus[PIX_W-1:0];
                    bit_next   = '0;
                    shift_next = '0;
                    phase_next = PH_LATCH;
                    tick_next  = at_least_one(cfg.latch_ticks);
                end
                else
                begin
                    // next pixel has been waiting at the read port
                    pos_next   = pos_plus[PIX_W-1:0];
                    bit_next   = '0;
                    shift_next = word;
                    phase_next = PH_HIGH;
                    tick_next  = at_least_one(word[WORD_W-1] ?
                                              TICK_W'(cfg.one_high_ticks) :
                                              TICK_W'(cfg.zero_high_ticks));
                end
            end
            PH_LATCH:
            begin
                if (tick_c > TICK_W'(1))
                begin
                    tick_next = tick_c - TICK_W'(1);
                end
                else
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            default: ;
        endcase

        if (!accept)
        begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
            bit_next   = bit_reg;
            tick_next  = tick_reg;
            shift_next = shift_reg;
        end

        we = accept && we_c;

        // prefetch pixel zero while idle, else the pixel after the current one
        raddr = (phase_next == PH_IDLE) ? '0 : pos_next + PIX_W'(1);
    end

    lsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (lsd_pkg::MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (pixel_index),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            bit_reg     <= '0;
            tick_reg    <= '0;
            shift_reg   <= '0;
            valid_reg   <= '0;
            raddr_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            bit_reg     <= bit_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            raddr_reg   <= raddr;
            fwd_hit_reg <= we && (pixel_index == raddr);
            if (we)
            begin
                valid_reg[pixel_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

endmodule

[sv/lsd_out_skid.sv]
`timescale 1ns / 1ps

module lsd_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lsd_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lsd_pkg::result_t out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    lsd_pkg::result_t out_data_reg;
    lsd_pkg::result_t skid_data_reg;
    logic             up_fire;

    assign in_ready  = !skid_valid_reg;
    assign up_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= up_fire;
            end
        end
        else if (up_fire)
        begin
            // output stalled: park the beat
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (up_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

[sv/addressable_led_strand_driver.sv]
`timescale 1ns / 1ps
// Result beats are combinational and registered in a two-entry output stage.
// Throughput: one input beat per cycle while in_ready is high; the stage absorbs a stall.
// Pixel store is a one-port-write, one-port-read RAM; the next pixel is prefetched.
// Reset (rst_n, async, active low): engine idle, registers at defaults, and
// per-entry valid flops make the whole pixel store read as zero at once.

module addressable_led_strand_driver (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [lsd_pkg::PIX_W-1:0]           pixel_index,
    input  logic signed [lsd_pkg::LEVEL_W-1:0]  red_in,
    input  logic signed [lsd_pkg::LEVEL_W-1:0]  green_in,
    input  logic signed [lsd_pkg::LEVEL_W-1:0]  blue_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                line_level,
    output logic                                busy_res,
    output logic [1:0]                          status
);

    lsd_pkg::cfg_t    cfg;
    lsd_pkg::result_t step_result;
    lsd_pkg::result_t out_result;
    logic             accept;

    assign accept     = in_valid && in_ready;
    assign line_level = out_result.line_level;
    assign busy_res   = out_result.busy_res;
    assign status     = out_result.status;

    lsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsd_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .mode        (mode),
        .pixel_index (pixel_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .result      (step_result)
    );

    lsd_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (step_result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_result)
    );

endmodule
